// File: rtl/aes_block_encrypt_unit_assert.svh
// assertion macros for the aes block encrypt unit checker
`ifndef AES_BLOCK_ENCRYPT_UNIT_ASSERT_SVH
`define AES_BLOCK_ENCRYPT_UNIT_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define ABE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("abe check failed");

// consequent must hold in the same cycle as the antecedent
`define ABE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("abe check failed");

`endif

// File: rtl/abe_pkg.sv
// types, constants and round functions shared by the aes block encrypt unit
package abe_pkg;

	typedef struct packed {
		logic [63:0] plain_high;
		logic [63:0] plain_low;
	} abe_in_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
	} abe_out_t;

	localparam int unsigned CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MODE   = 3'd0,
		REG_KEY0   = 3'd1,
		REG_KEY1   = 3'd2,
		REG_KEY2   = 3'd3,
		REG_KEY3   = 3'd4
	} abe_reg_t;

	typedef enum logic [1:0] {
		MODE_128 = 2'd0,
		MODE_192 = 2'd1,
		MODE_256 = 2'd2,
		MODE_ALT = 2'd3
	} abe_mode_t;

	localparam int unsigned RkRows = 15;

	localparam logic [7:0] SBOX_TBL [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic logic [7:0] sbox(input logic [7:0] b);
		return SBOX_TBL[b];
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// word with its first byte in bits 7:0
	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	// one cipher round, byte k of the state in bits 8k+7:8k
	function automatic logic [127:0] enc_round(input logic [127:0] s,
			input logic [127:0] rk, input logic last);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3;
		logic [127:0] r;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				t[4*c+k] = sbox(s[8*(4*((c+k)%4)+k) +: 8]);
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c];
			a1 = t[4*c+1];
			a2 = t[4*c+2];
			a3 = t[4*c+3];
			if (last) begin
				r[32*c +: 32] = {a3, a2, a1, a0};
			end else begin
				r[32*c      +: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
				r[32*c + 8  +: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
				r[32*c + 16 +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
				r[32*c + 24 +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
			end
		end
		return r ^ rk;
	endfunction

endpackage

// File: rtl/aes_block_encrypt_unit.sv
// aes block encryption with on-chip key expansion and a shared round unit
//
//  channel | signals                                  | role
//  in      | in_valid, in_ready, in_data              | plaintext block beat
//  out     | out_valid, out_ready, out_data           | ciphertext block beat
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | key and key length writes
//
// a block first fetches round key 0, then passes the initial key addition and
// each round through the shared round unit, then hands the result to the
// output register. the first block after a key
// or mode write first runs the key expansion, one key word per cycle, storing
// round keys as 128-bit rows in a memory with one write and one read port.
// in_ready is high only while idle; a waiting result holds in the output
// register and a finished block waits until that register frees up.
// reset clears control state and key registers; the round key memory is not
// cleared, since expansion always writes it before any read.
module aes_block_encrypt_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  abe_pkg::abe_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output abe_pkg::abe_out_t             out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [abe_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [63:0]                   cfg_data
);
	import abe_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXPAND = 5'b00010,
		ST_PREP   = 5'b00100,
		ST_ROUND  = 5'b01000,
		ST_DONE   = 5'b10000
	} abe_state_t;

	abe_state_t   state_q;
	logic [1:0]   mode_q;
	logic [63:0]  key_q [4];
	logic         sched_q;
	logic [5:0]   cnt_q;
	logic [2:0]   pos_q;
	logic [7:0]   rc_q;
	logic [31:0]  win_q [8];
	logic [95:0]  asm_q;
	logic [127:0] blk_q;
	logic [3:0]   rnd_q;
	logic [127:0] rk_q;
	logic [127:0] rk_mem [RkRows];
	abe_out_t     out_q;
	logic         out_valid_q;

	logic [3:0]   nk;
	logic [3:0]   nr;
	logic [5:0]   total;
	logic [255:0] kflat;
	logic [31:0]  wold;
	logic [31:0]  tmp_w;
	logic [31:0]  new_w;
	logic [3:0]   rd_addr;
	logic         in_acc;
	logic         cfg_acc;
	logic         cfg_hit;

	// key length decode, mode three acts as 256 bit
	always_comb begin
		unique case (abe_mode_t'(mode_q))
			MODE_128: nk = 4'd4;
			MODE_192: nk = 4'd6;
			default:  nk = 4'd8;
		endcase
	end
	assign nr    = nk + 4'd6;
	assign total = {nk, 2'b00} + 6'd28;
	assign kflat = {key_q[3], key_q[2], key_q[1], key_q[0]};

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_acc && (cfg_index <= CfgIdxW'(REG_KEY3));
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// next expanded key word, first byte in bits 7:0
	always_comb begin
		wold = win_q[nk[3:0] - 4'd1 > 4'd7 ? 3'd7 : 3'(nk - 4'd1)];
		if (pos_q == 3'd0) begin
			tmp_w = sub_word({win_q[0][7:0], win_q[0][31:8]}) ^ {24'd0, rc_q};
		end else if (nk == 4'd8 && pos_q == 3'd4) begin
			tmp_w = sub_word(win_q[0]);
		end else begin
			tmp_w = win_q[0];
		end
		if (cnt_q < {2'b00, nk}) begin
			new_w = kflat[32*cnt_q[2:0] +: 32];
		end else begin
			new_w = wold ^ tmp_w;
		end
	end

	// round key row address, one ahead of the round in use
	always_comb begin
		if (state_q == ST_ROUND && rnd_q != nr) begin
			rd_addr = rnd_q + 4'd1;
		end else if (state_q == ST_ROUND) begin
			rd_addr = rnd_q;
		end else begin
			rd_addr = 4'd0;
		end
	end

	// round key memory
	always_ff @(posedge clk) begin
		if (state_q == ST_EXPAND && cnt_q[1:0] == 2'd3) begin
			rk_mem[cnt_q[5:2]] <= {new_w, asm_q};
		end
		rk_q <= rk_mem[rd_addr];
	end

	// expansion window and row assembly
	always_ff @(posedge clk) begin
		if (state_q == ST_EXPAND) begin
			win_q[0] <= new_w;
			for (int k = 1; k < 8; k++) begin
				win_q[k] <= win_q[k-1];
			end
			unique case (cnt_q[1:0])
				2'd0: asm_q[31:0]  <= new_w;
				2'd1: asm_q[63:32] <= new_w;
				2'd2: asm_q[95:64] <= new_w;
				default: ;
			endcase
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0;
			for (int k = 0; k < 4; k++) begin
				key_q[k] <= 64'd0;
			end
		end else if (cfg_acc) begin
			unique case (cfg_index)
				REG_MODE: mode_q   <= cfg_data[1:0];
				REG_KEY0: key_q[0] <= cfg_data;
				REG_KEY1: key_q[1] <= cfg_data;
				REG_KEY2: key_q[2] <= cfg_data;
				REG_KEY3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sched_q     <= 1'b0;
			cnt_q       <= 6'd0;
			pos_q       <= 3'd0;
			rc_q        <= 8'h01;
			rnd_q       <= 4'd0;
			blk_q       <= 128'd0;
			out_valid_q <= 1'b0;
		end else begin
			// output beat valid: load from a finished block, drop when taken
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_hit) begin
						sched_q <= 1'b0;
					end
					if (in_acc) begin
						blk_q <= in_data;
						cnt_q <= 6'd0;
						pos_q <= 3'd0;
						rc_q  <= 8'h01;
						state_q <= (sched_q && !cfg_hit) ? ST_PREP : ST_EXPAND;
					end
				end
				ST_EXPAND: begin
					cnt_q <= cnt_q + 6'd1;
					pos_q <= ({1'b0, pos_q} == nk - 4'd1) ? 3'd0 : pos_q + 3'd1;
					if (pos_q == 3'd0 && cnt_q >= {2'b00, nk}) begin
						rc_q <= xt(rc_q);
					end
					if (cnt_q == total - 6'd1) begin
						sched_q <= 1'b1;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					rnd_q   <= 4'd0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (rnd_q == 4'd0) begin
						blk_q <= blk_q ^ rk_q;
					end else begin
						blk_q <= enc_round(blk_q, rk_q, rnd_q == nr);
					end
					if (rnd_q == nr) begin
						rnd_q   <= 4'd0;
						state_q <= ST_DONE;
					end else begin
						rnd_q <= rnd_q + 4'd1;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_q <= blk_q;
		end
	end

endmodule

// File: rtl/abe_checker.sv
// port level checks for the aes block encrypt unit
`include "aes_block_encrypt_unit_assert.svh"

module abe_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  abe_pkg::abe_in_t              in_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  abe_pkg::abe_out_t             out_data,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [abe_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [63:0]                   cfg_data
);
	import abe_pkg::*;

	// a stalled result holds its beat
	`ABE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	// an accepted block keeps the unit busy on the next cycle
	`ABE_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready && !cfg_ready)

	// no result can come out of the cycle after a block goes in
	`ABE_ASSERT_NEXT(a_no_instant_out, in_valid && in_ready && !out_valid, !out_valid)

	// key writes and blocks are taken only in the same idle window
	`ABE_ASSERT_SAME(a_cfg_idle, cfg_ready, in_ready)

endmodule

bind aes_block_encrypt_unit abe_checker u_abe_checker (.*);
